// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the checker files of this project.
// No dependencies; each file that asserts includes this header by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, idle while reset is asserted.
`define OFRP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition seen at one edge implies another at the next edge.
`define OFRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ofrp_pkg.sv -----
// Shared types, codes and constants of the OOK frame repeat packer.
// No dependencies; every other file of the block refers to it by scoped names.
package ofrp_pkg;

    localparam int MAX_PATTERN_BITS_DEF = 256;
    localparam int WORD_BITS_DEF        = 32;

    // Pattern words are always 32 bits wide.
    localparam int PAT_BITS  = 32;
    localparam int PAT_SHIFT = 5;

    localparam int CMD_W      = 2;
    localparam int LOAD_IDX_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int FRAG_W     = 9;
    localparam int CNT_W      = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAG_LEN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_LAST = 3'd3;

    typedef enum logic [1:0] {
        PH_FRAME = 2'd0,
        PH_PAUSE = 2'd1,
        PH_DONE  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [FRAG_W-1:0] frag_len;
        logic [CNT_W-1:0]  reps;
        logic [CNT_W-1:0]  pause_bits;
        logic              pause_last;
    } cfg_t;

    typedef struct packed {
        logic rewind;
        logic step;
    } stream_ctl_t;

endpackage

// ----- hdl/ofrp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies beyond ofrp_pkg for default widths.
module ofrp_ram #(
    parameter int WIDTH  = ofrp_pkg::PAT_BITS,
    parameter int DEPTH  = ofrp_pkg::MAX_PATTERN_BITS_DEF / ofrp_pkg::PAT_BITS,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/ofrp_stream.sv -----
// Stream position state and the one-bit step unit of the packer.
// Depends on ofrp_pkg (phase, config and control types).
module ofrp_stream #(
    parameter int MAX_PATTERN_BITS = ofrp_pkg::MAX_PATTERN_BITS_DEF,
    localparam int DEPTH = MAX_PATTERN_BITS / ofrp_pkg::PAT_BITS,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ofrp_pkg::stream_ctl_t         ctl,
    input  ofrp_pkg::cfg_t                cfg,
    input  logic [ofrp_pkg::PAT_BITS-1:0] pat_word,
    output logic                          bit_out,
    output ofrp_pkg::phase_t              phase,
    output logic [AW-1:0]                 word_idx
);

    localparam int POS_W = $clog2(MAX_PATTERN_BITS);
    localparam int LEN_W = POS_W + 1;

    ofrp_pkg::phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]             pos_reg, pos_next;
    logic [ofrp_pkg::CNT_W-1:0]   pause_reg, pause_next;
    logic [ofrp_pkg::CNT_W-1:0]   rep_reg, rep_next;

    logic [LEN_W-1:0]             eff_len;
    logic [LEN_W-1:0]             pos_inc;
    logic [ofrp_pkg::CNT_W-1:0]   eff_reps;
    logic [ofrp_pkg::CNT_W-1:0]   rep_inc;
    logic [ofrp_pkg::CNT_W-1:0]   pause_inc;

    always_comb
    begin
        // Zero length acts as one bit, long frames saturate at the store size.
        if (cfg.frag_len == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (32'(cfg.frag_len) > MAX_PATTERN_BITS)
        begin
            eff_len = LEN_W'(MAX_PATTERN_BITS);
        end
        else
        begin
            eff_len = LEN_W'(cfg.frag_len);
        end
        eff_reps  = (cfg.reps == '0) ? ofrp_pkg::CNT_W'(1) : cfg.reps;
        pos_inc   = {1'b0, pos_reg} + LEN_W'(1);
        rep_inc   = (rep_reg == '1) ? rep_reg : rep_reg + ofrp_pkg::CNT_W'(1);
        pause_inc = (pause_reg == '1) ? pause_reg : pause_reg + ofrp_pkg::CNT_W'(1);

        phase_next = phase_reg;
        pos_next   = pos_reg;
        pause_next = pause_reg;
        rep_next   = rep_reg;

        if (ctl.rewind)
        begin
            phase_next = ofrp_pkg::PH_FRAME;
            pos_next   = '0;
            pause_next = '0;
            rep_next   = '0;
        end
        else if (ctl.step)
        begin
            unique case (phase_reg)
                ofrp_pkg::PH_FRAME:
                begin
                    if (pos_inc >= eff_len)
                    begin
                        pos_next = '0;
                        rep_next = rep_inc;
                        if ((rep_inc >= eff_reps) &&
                            (!cfg.pause_last || (cfg.pause_bits == '0)))
                        begin
                            phase_next = ofrp_pkg::PH_DONE;
                        end
                        else if (cfg.pause_bits == '0)
                        begin
                            phase_next = ofrp_pkg::PH_FRAME;
                        end
                        else
                        begin
                            phase_next = ofrp_pkg::PH_PAUSE;
                            pause_next = '0;
                        end
                    end
                    else
                    begin
                        pos_next = pos_inc[POS_W-1:0];
                    end
                end
                ofrp_pkg::PH_PAUSE:
                begin
                    pause_next = pause_inc;
                    if (pause_inc >= cfg.pause_bits)
                    begin
                        pos_next   = '0;
                        phase_next = (rep_reg >= eff_reps) ? ofrp_pkg::PH_DONE
                                                           : ofrp_pkg::PH_FRAME;
                    end
                end
                ofrp_pkg::PH_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ofrp_pkg::PH_FRAME;
            pos_reg   <= '0;
            pause_reg <= '0;
            rep_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            pause_reg <= pause_next;
            rep_reg   <= rep_next;
        end
    end

    assign bit_out  = (phase_reg == ofrp_pkg::PH_FRAME) ?
                      pat_word[pos_reg[ofrp_pkg::PAT_SHIFT-1:0]] : 1'b0;
    assign phase    = phase_reg;
    assign word_idx = AW'(pos_reg >> ofrp_pkg::PAT_SHIFT);

endmodule

// ----- hdl/ook_frame_repeat_packer.sv -----
// Top level of the OOK frame repeat packer: command sequencer, registers,
// output register. Depends on ofrp_pkg, ofrp_ram and ofrp_stream.
//
// Usage: the input channel (in_valid/in_ready) takes one command beat with
// cmd, load_index and load_word. Restart rewinds the stream, load writes one
// 32-bit pattern word, read produces the next WORD_BITS stream bits, bit 0
// first. Every command gives exactly one beat on the output channel
// (out_valid/out_ready) with out_word, counted and finished.
// Configuration registers are written through cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high. Write them only while
// no command is in flight.
// Sequence: restart, load and unused commands pass through S_POST to the
// output register. A read shifts in WORD_BITS stream bits in S_RUN at one
// bit per cycle, held for a registered RAM read whenever the frame needs a
// pattern word other than the one held, as after reset, after a load or on
// entering another word; a completed stream goes straight to S_POST.
// A new command is accepted while a finished result waits in the output
// register; the sequencer stalls only when it must hand over a new result.
// Reset: stream rewound, registers at their defaults, pattern store
// undefined until loaded.
module ook_frame_repeat_packer #(
    parameter int MAX_PATTERN_BITS = ofrp_pkg::MAX_PATTERN_BITS_DEF,
    parameter int WORD_BITS        = ofrp_pkg::WORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ofrp_pkg::CMD_W-1:0]        cmd,
    input  logic [ofrp_pkg::LOAD_IDX_W-1:0]   load_index,
    input  logic [ofrp_pkg::PAT_BITS-1:0]     load_word,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [WORD_BITS-1:0]              out_word,
    output logic                              counted,
    output logic                              finished,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ofrp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ofrp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int DEPTH  = MAX_PATTERN_BITS / ofrp_pkg::PAT_BITS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BCNT_W = $clog2(WORD_BITS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_POST
    } state_t;

    state_t                  state_reg, state_next;
    logic [WORD_BITS-1:0]    word_reg, word_next;
    logic                    counted_reg, counted_next;
    logic [BCNT_W-1:0]       cnt_reg, cnt_next;
    logic                    fetch_ok_reg, fetch_ok_next;
    logic [AW-1:0]           fetch_idx_reg, fetch_idx_next;
    logic                    out_valid_reg, out_valid_next;
    logic [WORD_BITS-1:0]    out_word_reg, out_word_next;
    logic                    out_counted_reg, out_counted_next;
    logic                    out_finished_reg, out_finished_next;

    ofrp_pkg::cfg_t          cfg_reg;

    ofrp_pkg::stream_ctl_t   ctl;
    ofrp_pkg::phase_t        phase;
    logic                    bit_out;
    logic [AW-1:0]           word_idx;
    logic [ofrp_pkg::PAT_BITS-1:0] pat_word;

    logic                    in_accept;
    logic                    ld_ok;
    logic                    need_fetch;
    logic                    wr_en;
    logic                    rd_en;

    // Configuration registers; the write port never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frag_len   <= ofrp_pkg::FRAG_W'(1);
            cfg_reg.reps       <= ofrp_pkg::CNT_W'(1);
            cfg_reg.pause_bits <= '0;
            cfg_reg.pause_last <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ofrp_pkg::CFG_FRAG_LEN:   cfg_reg.frag_len   <= cfg_data[ofrp_pkg::FRAG_W-1:0];
                ofrp_pkg::CFG_REPS:       cfg_reg.reps       <= cfg_data[ofrp_pkg::CNT_W-1:0];
                ofrp_pkg::CFG_PAUSE:      cfg_reg.pause_bits <= cfg_data[ofrp_pkg::CNT_W-1:0];
                ofrp_pkg::CFG_PAUSE_LAST: cfg_reg.pause_last <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Pattern store: written by load commands, read while the step unit holds
    // whenever the frame position needs a word other than the one held.
    ofrp_ram #(
        .WIDTH (ofrp_pkg::PAT_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (AW'(load_index)),
        .wr_data (load_word),
        .rd_en   (rd_en),
        .rd_addr (word_idx),
        .rd_data (pat_word)
    );

    // Shared step unit: advances the stream by one bit per step.
    ofrp_stream #(
        .MAX_PATTERN_BITS (MAX_PATTERN_BITS)
    ) u_stream (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .cfg      (cfg_reg),
        .pat_word (pat_word),
        .bit_out  (bit_out),
        .phase    (phase),
        .word_idx (word_idx)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    // Loads beyond the store are dropped.
    assign ld_ok     = (32'(load_index) < DEPTH);
    // The word held at the RAM output must match the frame position.
    assign need_fetch = (phase == ofrp_pkg::PH_FRAME) &&
                        (!fetch_ok_reg || (fetch_idx_reg != word_idx));

    always_comb
    begin
        state_next        = state_reg;
        word_next         = word_reg;
        counted_next      = counted_reg;
        cnt_next          = cnt_reg;
        fetch_ok_next     = fetch_ok_reg;
        fetch_idx_next    = fetch_idx_reg;
        out_valid_next    = out_valid_reg;
        out_word_next     = out_word_reg;
        out_counted_next  = out_counted_reg;
        out_finished_next = out_finished_reg;
        ctl               = '0;
        wr_en             = 1'b0;
        rd_en             = 1'b0;

        // Drop the output beat once the receiver takes it.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    word_next    = '0;
                    counted_next = 1'b0;
                    cnt_next     = '0;
                    state_next   = S_POST;
                    unique case (cmd)
                        ofrp_pkg::CMD_RESTART:
                        begin
                            ctl.rewind = 1'b1;
                        end
                        ofrp_pkg::CMD_LOAD:
                        begin
                            wr_en         = ld_ok;
                            fetch_ok_next = 1'b0;
                        end
                        ofrp_pkg::CMD_READ:
                        begin
                            // A complete stream yields an uncounted zero word.
                            if (phase != ofrp_pkg::PH_DONE)
                            begin
                                counted_next = 1'b1;
                                state_next   = S_RUN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RUN:
            begin
                if (need_fetch)
                begin
                    // Hold the step while the RAM read lands.
                    rd_en          = 1'b1;
                    fetch_ok_next  = 1'b1;
                    fetch_idx_next = word_idx;
                end
                else
                begin
                    // Advance one bit; shift it in at the top so the first
                    // bit ends at bit 0.
                    ctl.step  = 1'b1;
                    word_next = {bit_out, word_reg[WORD_BITS-1:1]};
                    cnt_next  = cnt_reg + BCNT_W'(1);
                    if (cnt_reg == BCNT_W'(WORD_BITS - 1))
                    begin
                        state_next = S_POST;
                    end
                end
            end
            S_POST:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    out_word_next     = word_reg;
                    out_counted_next  = counted_reg;
                    out_finished_next = (phase == ofrp_pkg::PH_DONE);
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            word_reg         <= '0;
            counted_reg      <= 1'b0;
            cnt_reg          <= '0;
            fetch_ok_reg     <= 1'b0;
            fetch_idx_reg    <= '0;
            out_valid_reg    <= 1'b0;
            out_word_reg     <= '0;
            out_counted_reg  <= 1'b0;
            out_finished_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            word_reg         <= word_next;
            counted_reg      <= counted_next;
            cnt_reg          <= cnt_next;
            fetch_ok_reg     <= fetch_ok_next;
            fetch_idx_reg    <= fetch_idx_next;
            out_valid_reg    <= out_valid_next;
            out_word_reg     <= out_word_next;
            out_counted_reg  <= out_counted_next;
            out_finished_reg <= out_finished_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign counted   = out_counted_reg;
    assign finished  = out_finished_reg;

endmodule

// ----- hdl/ofrp_checker.sv -----
// Port-level checker for the OOK frame repeat packer, bound to the top level.
// Depends on assert_macros.svh and ofrp_pkg.
`include "assert_macros.svh"

module ofrp_checker #(
    parameter int WORD_BITS = ofrp_pkg::WORD_BITS_DEF
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic [ofrp_pkg::CMD_W-1:0] cmd,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [WORD_BITS-1:0]       out_word,
    input logic                       counted,
    input logic                       finished
);

    // One command at a time: the block is busy right after an accept.
    `OFRP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, (in_valid && in_ready), (!in_ready), "input accepted again without a busy cycle")

    // Words that do not count carry no stream bits.
    `OFRP_ASSERT(a_uncounted_zero, clk, rst_n, ((out_valid && !counted) |-> (out_word == '0)), "uncounted output word is not zero")

    // A restart accepted while no beat is held is answered with an unfinished, uncounted zero beat.
    `OFRP_ASSERT(a_restart_result, clk, rst_n, ((in_valid && in_ready && (cmd == ofrp_pkg::CMD_RESTART) && !out_valid) |=> ##1 (out_valid && !finished && !counted && (out_word == '0))), "restart result missing or wrong")

    // A stalled output beat holds.
    `OFRP_ASSERT_NEXT(a_out_hold, clk, rst_n, (out_valid && !out_ready), (out_valid && $stable(out_word) && $stable(counted) && $stable(finished)), "stalled output beat changed")

endmodule

bind ook_frame_repeat_packer ofrp_checker #(.WORD_BITS(WORD_BITS)) u_ofrp_checker (.*);
